/* rtl/core/rgba8_quad_mip_downsample_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the RGBA8 quad mip downsampler
// Concurrent property wrappers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef RGBA8_QUAD_MIP_DOWNSAMPLE_MACROS_SVH
`define RGBA8_QUAD_MIP_DOWNSAMPLE_MACROS_SVH

// same-cycle implication, off during reset
`define RQMD_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rqmd: property failed");

// next-cycle implication, off during reset
`define RQMD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rqmd: property failed");

// next-cycle implication that also runs through reset
`define RQMD_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("rqmd: property failed");

`endif

/* rtl/core/rqmd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqmd_pkg
// Types, stage counts and constant sRGB tables for the quad mip downsampler.
// ----------------------------------------------------------------------------
package rqmd_pkg;

  typedef enum logic [1:0] {
    MODE_LINEAR  = 2'd0,
    MODE_SRGB    = 2'd1,
    MODE_NORMAL  = 2'd2,
    MODE_OPACITY = 2'd3
  } filter_mode_t;

  typedef struct packed {
    logic [31:0] pixel_top_left;
    logic [31:0] pixel_top_right;
    logic [31:0] pixel_bottom_left;
    logic [31:0] pixel_bottom_right;
  } quad_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } pix_t;

  // front end result: channel sums, sRGB bytes, normal terms
  typedef struct packed {
    logic [3:0][9:0]  sum;
    logic [2:0][7:0]  srgb;
    logic [21:0]      q;
    logic [2:0][10:0] v;
    logic             cov;
    filter_mode_t     mode;
  } front_t;

  // data that rides alongside the normal unit
  typedef struct packed {
    logic [3:0][9:0] sum;
    logic [2:0][7:0] srgb;
    logic            cov;
    filter_mode_t    mode;
  } side_t;

  localparam int FRONT_STAGES  = 4;
  localparam int ISQ_ITERS     = 19;
  localparam int ISQ_PER_STAGE = 4;
  localparam int ISQ_STAGES    = (ISQ_ITERS + ISQ_PER_STAGE - 1) / ISQ_PER_STAGE;
  localparam int ISQ_TOP_SHIFT = 2 * (ISQ_ITERS - 1);
  localparam int DIV_STAGES    = 3;
  localparam int NORM_STAGES   = ISQ_STAGES + DIV_STAGES;
  localparam int PIPE_STAGES   = FRONT_STAGES + NORM_STAGES + 1;

  localparam longint unsigned Q30_ONE   = 64'd1 << 30;
  localparam longint unsigned LIN_D255  = 64'd1292 * 64'd255;
  localparam longint unsigned LIN_D510  = 64'd1292 * 64'd510;
  localparam longint unsigned GAM_D255  = 64'd1055 * 64'd255;
  localparam longint unsigned GAM_D510  = 64'd1055 * 64'd510;

  typedef logic [255:0][15:0] lin_tab_t;
  typedef logic [255:0][17:0] thr_tab_t;

  function automatic longint unsigned pow5_q30(longint unsigned r);
    longint unsigned p;
    p = r;
    for (int i = 0; i < 4; i++) begin
      p = (p * r) >> 30;
    end
    return p;
  endfunction

  // sRGB to linear of num/255 (half = 0) or num/510 (half = 1), Q30
  function automatic longint unsigned lin_q30(longint unsigned num, logic half);
    longint unsigned den;
    longint unsigned x;
    longint unsigned t;
    longint unsigned s;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned mid;
    den = half ? 64'd510 : 64'd255;
    if (num * 64'd100000 <= 64'd4045 * den) begin
      if (half) begin
        return (((num * 64'd100) << 30) + LIN_D510 / 2) / LIN_D510;
      end
      return (((num * 64'd100) << 30) + LIN_D255 / 2) / LIN_D255;
    end
    x = 64'd1000 * num + 64'd55 * den;
    if (half) begin
      t = ((x << 30) + GAM_D510 / 2) / GAM_D510;
    end else begin
      t = ((x << 30) + GAM_D255 / 2) / GAM_D255;
    end
    if (t > Q30_ONE) begin
      t = Q30_ONE;
    end
    s  = (t * t) >> 30;
    lo = 64'd0;
    hi = Q30_ONE;
    for (int i = 0; i < 32; i++) begin
      if (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        if (pow5_q30(mid) <= s) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
    end
    return (s * lo + Q30_ONE / 2) >> 30;
  endfunction

  function automatic lin_tab_t build_lin_tab();
    lin_tab_t        tab;
    longint unsigned e;
    for (int k = 0; k < 256; k++) begin
      e = (lin_q30(64'(k), 1'b0) * 64'd65535 + Q30_ONE / 2) >> 30;
      if (e > 64'd65535) begin
        e = 64'd65535;
      end
      tab[k] = e[15:0];
    end
    return tab;
  endfunction

  // smallest linear sum that encodes to at least byte k
  function automatic thr_tab_t build_thr_tab();
    thr_tab_t        tab;
    longint unsigned thr;
    longint unsigned c;
    tab[0] = 18'd0;
    for (int k = 1; k < 256; k++) begin
      thr = lin_q30(64'(2 * k - 1), 1'b1);
      c = (thr * 64'd262140 + Q30_ONE - 64'd1) >> 30;
      tab[k] = c[17:0];
    end
    return tab;
  endfunction

  localparam lin_tab_t LIN_TAB = build_lin_tab();
  localparam thr_tab_t THR_TAB = build_thr_tab();

endpackage

/* rtl/core/rqmd_chan_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqmd_chan_if
// Valid/ready channel with a typed payload.
// ----------------------------------------------------------------------------
interface rqmd_chan_if #(
  parameter type payload_t = logic [31:0]
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/rqmd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqmd_front
// Four-stage front end: channel sums, sRGB decode and re-encode search,
// normal vector terms and squared length.
// ----------------------------------------------------------------------------
module rqmd_front (
  input  logic                   clk,
  input  logic                   adv,
  input  rqmd_pkg::quad_t        quad,
  input  rqmd_pkg::filter_mode_t mode,
  output rqmd_pkg::front_t       res
);

  logic [3:0][31:0] px;

  // stage 1
  logic [3:0][9:0]        s1_sum;
  logic [2:0][3:0][15:0]  s1_lin;
  logic                   s1_cov;
  rqmd_pkg::filter_mode_t s1_mode;
  logic [3:0][9:0]        sum_c;
  logic [2:0][3:0][15:0]  lin_c;
  logic                   cov_c;

  // stage 2
  logic [2:0][17:0]       s2_lsum;
  logic [2:0][20:0]       s2_sq;
  logic [2:0][10:0]       s2_v;
  logic [3:0][9:0]        s2_sum;
  logic                   s2_cov;
  rqmd_pkg::filter_mode_t s2_mode;
  logic [2:0][17:0]       lsum_c;
  logic [2:0][20:0]       sq_c;
  logic [2:0][10:0]       v_c;

  // stage 3
  logic [21:0]            s3_q;
  logic [2:0][7:0]        s3_code;
  logic [2:0][17:0]       s3_lsum;
  logic [2:0][10:0]       s3_v;
  logic [3:0][9:0]        s3_sum;
  logic                   s3_cov;
  rqmd_pkg::filter_mode_t s3_mode;
  logic [2:0][7:0]        hi_code_c;

  // stage 4
  logic [2:0][7:0]        s4_srgb;
  logic [21:0]            s4_q;
  logic [2:0][10:0]       s4_v;
  logic [3:0][9:0]        s4_sum;
  logic                   s4_cov;
  rqmd_pkg::filter_mode_t s4_mode;
  logic [2:0][7:0]        lo_code_c;

  assign px = {quad.pixel_bottom_right, quad.pixel_bottom_left,
               quad.pixel_top_right, quad.pixel_top_left};

  always_comb begin
    cov_c = 1'b0;
    for (int c = 0; c < 4; c++) begin
      sum_c[c] = 10'(px[0][8*c +: 8]) + 10'(px[1][8*c +: 8])
               + 10'(px[2][8*c +: 8]) + 10'(px[3][8*c +: 8]);
    end
    for (int c = 0; c < 3; c++) begin
      for (int p = 0; p < 4; p++) begin
        lin_c[c][p] = rqmd_pkg::LIN_TAB[px[p][8*c +: 8]];
      end
    end
    for (int p = 0; p < 4; p++) begin
      cov_c = cov_c | px[p][31];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sum  <= sum_c;
      s1_lin  <= lin_c;
      s1_cov  <= cov_c;
      s1_mode <= mode;
    end
  end

  // normal component v = 2*sum - 1020 and its square
  always_comb begin
    logic signed [11:0] vv;
    logic signed [23:0] prod;
    for (int c = 0; c < 3; c++) begin
      lsum_c[c] = 18'(s1_lin[c][0]) + 18'(s1_lin[c][1])
                + 18'(s1_lin[c][2]) + 18'(s1_lin[c][3]);
      vv        = $signed({1'b0, s1_sum[c], 1'b0}) - 12'sd1020;
      prod      = vv * vv;
      v_c[c]    = vv[10:0];
      sq_c[c]   = prod[20:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_lsum <= lsum_c;
      s2_sq   <= sq_c;
      s2_v    <= v_c;
      s2_sum  <= s1_sum;
      s2_cov  <= s1_cov;
      s2_mode <= s1_mode;
    end
  end

  // binary search of the encode thresholds, upper four bits
  always_comb begin
    logic [7:0] cand;
    for (int c = 0; c < 3; c++) begin
      hi_code_c[c] = 8'd0;
      for (int k = 7; k >= 4; k--) begin
        cand = hi_code_c[c] | (8'd1 << k);
        if (rqmd_pkg::THR_TAB[cand] <= s2_lsum[c]) begin
          hi_code_c[c] = cand;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_q    <= 22'(s2_sq[0]) + 22'(s2_sq[1]) + 22'(s2_sq[2]);
      s3_code <= hi_code_c;
      s3_lsum <= s2_lsum;
      s3_v    <= s2_v;
      s3_sum  <= s2_sum;
      s3_cov  <= s2_cov;
      s3_mode <= s2_mode;
    end
  end

  // lower four bits of the search
  always_comb begin
    logic [7:0] cand;
    for (int c = 0; c < 3; c++) begin
      lo_code_c[c] = s3_code[c];
      for (int k = 3; k >= 0; k--) begin
        cand = lo_code_c[c] | (8'd1 << k);
        if (rqmd_pkg::THR_TAB[cand] <= s3_lsum[c]) begin
          lo_code_c[c] = cand;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_srgb <= lo_code_c;
      s4_q    <= s3_q;
      s4_v    <= s3_v;
      s4_sum  <= s3_sum;
      s4_cov  <= s3_cov;
      s4_mode <= s3_mode;
    end
  end

  assign res.sum  = s4_sum;
  assign res.srgb = s4_srgb;
  assign res.q    = s4_q;
  assign res.v    = s4_v;
  assign res.cov  = s4_cov;
  assign res.mode = s4_mode;

endmodule

/* rtl/core/rqmd_norm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqmd_norm
// Normal renormalization: pipelined integer square root of the squared
// length, then a pipelined rounded divide per component.
// ----------------------------------------------------------------------------
module rqmd_norm (
  input  logic             clk,
  input  logic             adv,
  input  logic [21:0]      q,
  input  logic [2:0][10:0] v,
  output logic [2:0][7:0]  xyz
);

  localparam int LAST = rqmd_pkg::ISQ_STAGES - 1;

  logic [38:0]      isq_rem  [rqmd_pkg::ISQ_STAGES];
  logic [38:0]      isq_root [rqmd_pkg::ISQ_STAGES];
  logic [2:0][10:0] isq_v    [rqmd_pkg::ISQ_STAGES];
  logic             isq_zero [rqmd_pkg::ISQ_STAGES];

  for (genvar s = 0; s < rqmd_pkg::ISQ_STAGES; s++) begin : g_isq
    logic [38:0]      rem_in;
    logic [38:0]      root_in;
    logic [2:0][10:0] v_in;
    logic             zero_in;
    logic [38:0]      rem_c;
    logic [38:0]      root_c;

    if (s == 0) begin : g_first
      assign rem_in  = {1'b0, q, 16'd0};
      assign root_in = 39'd0;
      assign v_in    = v;
      assign zero_in = (q == 22'd0);
    end else begin : g_rest
      assign rem_in  = isq_rem[s-1];
      assign root_in = isq_root[s-1];
      assign v_in    = isq_v[s-1];
      assign zero_in = isq_zero[s-1];
    end

    always_comb begin
      logic [38:0] bitv;
      rem_c  = rem_in;
      root_c = root_in;
      for (int k = 0; k < rqmd_pkg::ISQ_PER_STAGE; k++) begin
        if (s * rqmd_pkg::ISQ_PER_STAGE + k < rqmd_pkg::ISQ_ITERS) begin
          bitv = 39'd1 << (rqmd_pkg::ISQ_TOP_SHIFT - 2 * (s * rqmd_pkg::ISQ_PER_STAGE + k));
          if (rem_c >= root_c + bitv) begin
            rem_c  = rem_c - (root_c + bitv);
            root_c = (root_c >> 1) + bitv;
          end else begin
            root_c = root_c >> 1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        isq_rem[s]  <= rem_c;
        isq_root[s] <= root_c;
        isq_v[s]    <= v_in;
        isq_zero[s] <= zero_in;
      end
    end
  end

  // divide setup: numerator, denominator, sign and saturation
  logic [19:0]      len;
  logic [2:0][28:0] num_c;
  logic [20:0]      den_c;
  logic [2:0]       pos_c;
  logic [2:0]       sat_c;

  logic [2:0][28:0] d0_num;
  logic [20:0]      d0_den;
  logic [2:0]       d0_pos;
  logic [2:0]       d0_sat;
  logic             d0_zero;

  assign len   = isq_root[LAST][19:0];
  assign den_c = {len, 1'b0};

  always_comb begin
    logic signed [21:0] t;
    logic signed [29:0] n;
    for (int c = 0; c < 3; c++) begin
      t = $signed({2'b00, len}) + $signed({{3{isq_v[LAST][c][10]}}, isq_v[LAST][c], 8'd0});
      n = $signed({t, 8'd0}) - 30'(t);
      pos_c[c] = !n[29] && (n != 30'sd0);
      num_c[c] = {1'b0, n[27:0]} + 29'(len);
      sat_c[c] = num_c[c] >= {den_c, 8'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d0_num  <= num_c;
      d0_den  <= den_c;
      d0_pos  <= pos_c;
      d0_sat  <= sat_c;
      d0_zero <= isq_zero[LAST];
    end
  end

  // restoring divide, upper quotient bits
  logic [2:0][28:0] hi_rem_c;
  logic [2:0][3:0]  hi_quo_c;
  logic [2:0][28:0] d1_rem;
  logic [2:0][3:0]  d1_quo;
  logic [20:0]      d1_den;
  logic [2:0]       d1_pos;
  logic [2:0]       d1_sat;
  logic             d1_zero;

  always_comb begin
    logic [28:0] dd;
    for (int c = 0; c < 3; c++) begin
      hi_rem_c[c] = d0_num[c];
      hi_quo_c[c] = 4'd0;
      for (int k = 7; k >= 4; k--) begin
        dd = 29'(d0_den) << k;
        if (hi_rem_c[c] >= dd) begin
          hi_rem_c[c]      = hi_rem_c[c] - dd;
          hi_quo_c[c][k-4] = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_rem  <= hi_rem_c;
      d1_quo  <= hi_quo_c;
      d1_den  <= d0_den;
      d1_pos  <= d0_pos;
      d1_sat  <= d0_sat;
      d1_zero <= d0_zero;
    end
  end

  // lower quotient bits and final select
  logic [2:0][7:0] byte_c;

  always_comb begin
    logic [28:0] rem;
    logic [3:0]  quo;
    logic [28:0] dd;
    for (int c = 0; c < 3; c++) begin
      rem = d1_rem[c];
      quo = 4'd0;
      for (int k = 3; k >= 0; k--) begin
        dd = 29'(d1_den) << k;
        if (rem >= dd) begin
          rem    = rem - dd;
          quo[k] = 1'b1;
        end
      end
      priority if (d1_zero) begin
        byte_c[c] = 8'd128;
      end else if (!d1_pos[c]) begin
        byte_c[c] = 8'd0;
      end else if (d1_sat[c]) begin
        byte_c[c] = 8'd255;
      end else begin
        byte_c[c] = {d1_quo[c], quo};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xyz <= byte_c;
    end
  end

endmodule

/* rtl/core/rgba8_quad_mip_downsample.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgba8_quad_mip_downsample
// 2x2 box-filter mip downsampler for RGBA8 with linear, sRGB, normal-map
// and opacity-mask modes.
// ----------------------------------------------------------------------------
//   channel   dir   payload                          role
//   quad_in   in    four RGBA8 pixels (quad_t)        source quad request
//   pix_out   out   four bytes (pix_t)                filtered mip pixel
//   cfg       in    filter_mode, 2 bits               mode register write
//
// One quad per cycle unless the output stalls; the result path is set by the
// square root of the normal path (19 iterations over five stages) followed
// by a three-stage divide. Reset clears all valid bits and the mode to
// linear. A stalled output freezes every stage and drops quad_in.ready;
// cfg is always ready.
// ----------------------------------------------------------------------------
module rgba8_quad_mip_downsample (
  input  logic        clk,
  input  logic        rst,
  rqmd_chan_if.sink   quad_in,
  rqmd_chan_if.source pix_out,
  rqmd_chan_if.sink   cfg
);

  localparam int LAST = rqmd_pkg::PIPE_STAGES - 1;
  localparam int SIDE_LAST = rqmd_pkg::NORM_STAGES - 1;

  rqmd_pkg::filter_mode_t          filter_mode;
  logic [rqmd_pkg::PIPE_STAGES-1:0] vld;
  logic                            adv;
  rqmd_pkg::front_t                front_res;
  rqmd_pkg::side_t                 side_q [rqmd_pkg::NORM_STAGES];
  rqmd_pkg::side_t                 side;
  logic [2:0][7:0]                 norm_xyz;
  rqmd_pkg::pix_t                  result;
  rqmd_pkg::pix_t                  pix;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode <= rqmd_pkg::MODE_LINEAR;
    end else if (cfg.valid && cfg.ready) begin
      filter_mode <= rqmd_pkg::filter_mode_t'(cfg.data);
    end
  end

  // whole pipe advances unless the output holds an untaken result
  assign adv           = !vld[LAST] || pix_out.ready;
  assign quad_in.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAST-1:0], quad_in.valid};
    end
  end

  rqmd_front u_front (
    .clk  (clk),
    .adv  (adv),
    .quad (quad_in.data),
    .mode (filter_mode),
    .res  (front_res)
  );

  rqmd_norm u_norm (
    .clk (clk),
    .adv (adv),
    .q   (front_res.q),
    .v   (front_res.v),
    .xyz (norm_xyz)
  );

  // carry the non-normal results alongside the normal unit
  always_ff @(posedge clk) begin
    if (adv) begin
      side_q[0].sum  <= front_res.sum;
      side_q[0].srgb <= front_res.srgb;
      side_q[0].cov  <= front_res.cov;
      side_q[0].mode <= front_res.mode;
      for (int i = 1; i < rqmd_pkg::NORM_STAGES; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  assign side = side_q[SIDE_LAST];

  always_comb begin
    logic [10:0] rounded;
    logic [3:0][7:0] avg;
    for (int c = 0; c < 4; c++) begin
      rounded = 11'(side.sum[c]) + 11'd2;
      avg[c]  = rounded[9:2];
    end
    result.out_alpha = avg[3];
    if (side.mode == rqmd_pkg::MODE_OPACITY && side.cov && !avg[3][7]) begin
      result.out_alpha = 8'd128;
    end
    unique case (side.mode)
      rqmd_pkg::MODE_NORMAL: begin
        result.out_red   = norm_xyz[0];
        result.out_green = norm_xyz[1];
        result.out_blue  = norm_xyz[2];
      end
      rqmd_pkg::MODE_SRGB: begin
        result.out_red   = side.srgb[0];
        result.out_green = side.srgb[1];
        result.out_blue  = side.srgb[2];
      end
      default: begin
        result.out_red   = avg[0];
        result.out_green = avg[1];
        result.out_blue  = avg[2];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix <= result;
    end
  end

  assign pix_out.valid = vld[LAST];
  assign pix_out.data  = pix;

endmodule

/* rtl/core/rqmd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rqmd_checker
// Port-level properties of the quad mip downsampler, bound to the top.
// ----------------------------------------------------------------------------
`include "rgba8_quad_mip_downsample_macros.svh"

module rqmd_checker (
  input logic           clk,
  input logic           rst,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input rqmd_pkg::pix_t out_data
);

  `RQMD_ASSERT_NEXT(a_out_hold_valid, clk, rst, out_valid && !out_ready, out_valid)
  `RQMD_ASSERT_NEXT(a_out_hold_data, clk, rst, out_valid && !out_ready, $stable(out_data))
  `RQMD_ASSERT_IMPLY(a_ready_when_free, clk, rst, !out_valid || out_ready, in_ready)
  `RQMD_ASSERT_ALWAYS_NEXT(a_reset_empty, clk, rst, !out_valid)

endmodule

bind rgba8_quad_mip_downsample rqmd_checker u_rqmd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (quad_in.ready),
  .out_valid (pix_out.valid),
  .out_ready (pix_out.ready),
  .out_data  (pix_out.data)
);
